// ===== sv/bbe_pkg.sv =====
package bbe_pkg;

    localparam int IMG_W_BITS    = 11;
    localparam int IMG_H_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int CHAN_BITS     = 8;
    localparam int SUM_BITS      = 12;
    localparam int COUNT_BITS    = 4;
    localparam int RECIP_BITS    = 16;
    localparam int RECIP_SHIFT   = 16;

    localparam int IMAGE_WIDTH_RESET  = 1024;
    localparam int IMAGE_HEIGHT_RESET = 768;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line;

    typedef struct packed {
        logic                 action;
        logic [CHAN_BITS-1:0] in_red;
        logic [CHAN_BITS-1:0] in_green;
        logic [CHAN_BITS-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0] out_red;
        logic [CHAN_BITS-1:0] out_green;
        logic [CHAN_BITS-1:0] out_blue;
        logic                 last_of_image;
    } t_out_item;

    // ceil(2^16 / (2*count)): exact for every rounded mean of 8-bit samples
    function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] count);
        case (count)
            4'd1:    recip = 16'd32768;
            4'd2:    recip = 16'd16384;
            4'd3:    recip = 16'd10923;
            4'd4:    recip = 16'd8192;
            4'd6:    recip = 16'd5462;
            4'd9:    recip = 16'd3641;
            default: recip = 16'd32768;
        endcase
    endfunction

endpackage

// ===== sv/bbe_ram.sv =====
module bbe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== sv/box_blur_3x3_edge_aware.sv =====
// Edge-aware 3x3 box blur over an RGB pixel stream in raster order. One beat is accepted
// per clock while the output queue has a free slot, pixels and drain beats alike; each
// result is the per-channel mean of the in-image neighbours, rounded half up. Results lag
// the pixel stream by width+1 pixels, and drain beats sent after the last pixel release
// the tail, the final one flagged. Results pass stage 1 and stage 2 into the output queue.
// The two line stores share one RAM of MAX_WIDTH words, read once per beat and written
// back once per pixel beat; they need no clearing after reset. A four-beat output queue
// keeps input flowing while the output stalls. Writing width or height restarts the stream.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bbe_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bbe_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bbe_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    import bbe_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RST_W      = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_BITS  = SUM_BITS + 1 + RECIP_BITS;

    typedef t_pix t_col [3];

    // configuration and counters
    logic [CW-1:0]         r_wm1, n_wm1;
    logic [IMG_H_BITS-1:0] r_hm1, n_hm1;
    logic [CW-1:0]         r_in_col, n_in_col, r_out_col, n_out_col;
    logic [IMG_H_BITS-1:0] r_in_row, n_in_row, r_out_row, n_out_row;

    logic                  cfg_hit;
    logic [IMG_W_BITS-1:0] cfg_w;
    logic [IMG_H_BITS-1:0] cfg_h;

    logic          in_fire;
    logic          done;
    logic          is_pix;
    logic          due;
    logic          emit;
    logic          col_last;
    logic          row_last;
    logic          last_now;
    logic          preload;
    logic [CW-1:0] rd_addr_a;
    t_pix          in_pix;

    // stage 1
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_wr;
    logic          r_s1_preload;
    logic [CW-1:0] r_s1_addr;
    t_pix          r_s1_pix;
    logic          r_s1_left;
    logic          r_s1_right;
    logic          r_s1_top;
    logic          r_s1_bot;
    logic          r_s1_last;
    logic          r_fwd_a;
    logic          r_fwd_b;
    t_line         r_fwd_data;

    t_line         ram_a, ram_b, line_a, line_b;
    logic          wr_en;
    t_line         wr_data;
    t_col          r_win [3];
    t_col          col_new, col_pre, col_l, col_c;
    logic [2:0]    row_en;
    logic [1:0]    ncols, nrows;
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   s1_sum [3];

    // stage 2
    logic                  r_s2_valid;
    logic [SUM_BITS-1:0]   r_s2_sum [3];
    logic [COUNT_BITS-1:0] r_s2_count;
    logic [RECIP_BITS-1:0] r_s2_recip;
    logic                  r_s2_last;
    logic [SUM_BITS:0]     s2_x [3];
    logic [PROD_BITS-1:0]  s2_prod [3];
    logic [CHAN_BITS-1:0]  s2_q [3];
    t_out_item             s2_item;

    // output queue
    t_out_item      r_fifo [FIFO_DEPTH];
    logic [FAW-1:0] r_head, r_tail;
    logic [FCW-1:0] r_fill, n_fill;
    logic [FCW-1:0] r_credit, n_credit;
    logic           pop;
    logic           reserve;

    assign o_cfg_ready = 1'b1;
    assign cfg_w       = i_cfg_data[IMG_W_BITS-1:0];
    assign cfg_h       = i_cfg_data[IMG_H_BITS-1:0];
    assign cfg_hit     = i_cfg_valid &&
                         (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT);

    always_comb begin
        n_wm1 = r_wm1;
        n_hm1 = r_hm1;
        if (i_cfg_valid && i_cfg_index == CFG_IMAGE_WIDTH) begin
            if (cfg_w == '0) begin
                n_wm1 = '0;
            end else if (int'(cfg_w) > MAX_WIDTH) begin
                n_wm1 = CW'(MAX_WIDTH - 1);
            end else begin
                n_wm1 = CW'(cfg_w - 1'b1);
            end
        end
        if (i_cfg_valid && i_cfg_index == CFG_IMAGE_HEIGHT) begin
            n_hm1 = (cfg_h == '0) ? '0 : cfg_h - 1'b1;
        end
    end

    // accept-side decisions
    assign in_fire  = i_in_valid && o_in_ready;
    assign done     = r_in_row > r_hm1;
    assign is_pix   = !done && (i_in.action == ACTION_PIXEL);
    assign due      = (r_in_row > 16'd1) || (r_in_row == 16'd1 && r_in_col != '0);
    assign emit     = (is_pix && due) || done;
    assign col_last = r_out_col == r_wm1;
    assign row_last = r_out_row == r_hm1;
    assign last_now = col_last && row_last;
    assign preload  = done && r_hm1 == '0 && r_out_row == '0 && r_out_col == '0;
    assign rd_addr_a = is_pix ? r_in_col : (col_last ? '0 : r_out_col + CW'(1));
    assign in_pix   = '{red: i_in.in_red, green: i_in.in_green, blue: i_in.in_blue};

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_fire && is_pix) begin
            if (r_in_col == r_wm1) begin
                n_in_col = '0;
                n_in_row = r_in_row + 16'd1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (in_fire && emit) begin
            if (last_now) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (col_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + 16'd1;
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        if (cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1     <= CW'(RST_W - 1);
            r_hm1     <= IMG_H_BITS'(IMAGE_HEIGHT_RESET - 1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_wm1     <= n_wm1;
            r_hm1     <= n_hm1;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // line stores: older row in the upper half of the word, newer row in the lower
    bbe_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_s1_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b ('0),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s1_emit    <= 1'b0;
            r_s1_wr      <= 1'b0;
            r_s1_preload <= 1'b0;
            r_fwd_a      <= 1'b0;
            r_fwd_b      <= 1'b0;
        end else begin
            r_s1_valid   <= in_fire && (is_pix || done);
            r_s1_emit    <= in_fire && emit;
            r_s1_wr      <= in_fire && is_pix;
            r_s1_preload <= in_fire && preload;
            r_fwd_a      <= in_fire && wr_en && (rd_addr_a == r_s1_addr);
            r_fwd_b      <= in_fire && wr_en && (r_s1_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        if (in_fire) begin
            r_s1_addr  <= rd_addr_a;
            r_s1_pix   <= is_pix ? in_pix : '0;
            r_s1_left  <= r_out_col != '0;
            r_s1_right <= !col_last;
            r_s1_top   <= r_out_row != '0;
            r_s1_bot   <= !row_last;
            r_s1_last  <= last_now;
        end
    end

    // hold the beat just written when the next read hits the same word
    assign line_a  = r_fwd_a ? r_fwd_data : ram_a;
    assign line_b  = r_fwd_b ? r_fwd_data : ram_b;
    assign wr_en   = r_s1_valid && r_s1_wr;
    assign wr_data = '{older: line_a.newer, newer: r_s1_pix};
    assign row_en  = {r_s1_bot, 1'b1, r_s1_top};

    always_comb begin
        col_new[0] = line_a.older;
        col_new[1] = line_a.newer;
        col_new[2] = r_s1_pix;
        col_pre[0] = line_b.older;
        col_pre[1] = line_b.newer;
        col_pre[2] = '0;
        if (r_s1_preload) begin
            col_l = r_win[2];
            col_c = col_pre;
        end else begin
            col_l = r_win[1];
            col_c = r_win[2];
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s1_sum[ch] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (row_en[i]) begin
                if (r_s1_left) begin
                    s1_sum[0] = s1_sum[0] + SUM_BITS'(col_l[i].red);
                    s1_sum[1] = s1_sum[1] + SUM_BITS'(col_l[i].green);
                    s1_sum[2] = s1_sum[2] + SUM_BITS'(col_l[i].blue);
                end
                s1_sum[0] = s1_sum[0] + SUM_BITS'(col_c[i].red);
                s1_sum[1] = s1_sum[1] + SUM_BITS'(col_c[i].green);
                s1_sum[2] = s1_sum[2] + SUM_BITS'(col_c[i].blue);
                if (r_s1_right) begin
                    s1_sum[0] = s1_sum[0] + SUM_BITS'(col_new[i].red);
                    s1_sum[1] = s1_sum[1] + SUM_BITS'(col_new[i].green);
                    s1_sum[2] = s1_sum[2] + SUM_BITS'(col_new[i].blue);
                end
            end
        end
    end

    assign ncols = 2'd1 + 2'(r_s1_left) + 2'(r_s1_right);
    assign nrows = 2'd1 + 2'(r_s1_top) + 2'(r_s1_bot);
    assign count = COUNT_BITS'(ncols) * COUNT_BITS'(nrows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (cfg_hit) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (r_s1_valid) begin
            r_win[0] <= col_l;
            r_win[1] <= col_c;
            r_win[2] <= col_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sum   <= s1_sum;
        r_s2_count <= count;
        r_s2_recip <= recip(count);
        r_s2_last  <= r_s1_last;
    end

    // rounded mean: (2*sum + count) / (2*count) by reciprocal
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s2_x[ch]    = {r_s2_sum[ch], 1'b0} + (SUM_BITS + 1)'(r_s2_count);
            s2_prod[ch] = PROD_BITS'(s2_x[ch]) * PROD_BITS'(r_s2_recip);
            s2_q[ch]    = s2_prod[ch][RECIP_SHIFT +: CHAN_BITS];
        end
    end

    assign s2_item = '{out_red: s2_q[0], out_green: s2_q[1], out_blue: s2_q[2],
                       last_of_image: r_s2_last};

    // output queue, space reserved at accept
    assign pop         = o_out_valid && i_out_ready;
    assign reserve     = in_fire && emit;
    assign o_in_ready  = r_credit < FCW'(FIFO_DEPTH);
    assign o_out_valid = r_fill != '0;
    assign o_out       = r_fifo[r_head];

    always_comb begin
        n_fill   = r_fill;
        n_credit = r_credit;
        if (r_s2_valid && !pop) begin
            n_fill = r_fill + FCW'(1);
        end else if (!r_s2_valid && pop) begin
            n_fill = r_fill - FCW'(1);
        end
        if (reserve && !pop) begin
            n_credit = r_credit + FCW'(1);
        end else if (!reserve && pop) begin
            n_credit = r_credit - FCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (r_s2_valid) begin
                r_tail <= r_tail + FAW'(1);
            end
            if (pop) begin
                r_head <= r_head + FAW'(1);
            end
            r_fill   <= n_fill;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_tail] <= s2_item;
        end
    end

endmodule
